[sv/hcte_pkg.sv]
// ----------------------------------------------------------------------------
// hcte_pkg: shared definitions for the content type extractor
// Frame layout constants, the one-hot parse phase type and the search pattern.
// ----------------------------------------------------------------------------
`default_nettype none

package hcte_pkg;

    // Frame layout and counter width.
    localparam int LINK_HEADER_BYTES = 14;
    localparam int POSITION_BITS     = 16;

    // Search pattern "Content-Type: " and its length.
    localparam int PAT_LEN  = 14;
    localparam int PAT_BITS = $clog2(PAT_LEN + 1);

    // Characters with a special meaning.
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_NUL  = 8'h00;
    localparam logic [7:0] CHAR_C    = 8'h43;

    // Reset value of the source address register (127.0.0.1).
    localparam logic [31:0] SOURCE_ADDRESS_RESET = 32'h7F00_0001;

    // Parse phase, one-hot.
    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_SEARCH = 4'b0010,
        PH_VALUE  = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    // Character of the search pattern at a given index.
    function automatic logic [7:0] pattern_char(input logic [PAT_BITS-1:0] idx);
        logic [7:0] ch;
        case (idx)
            PAT_BITS'(0):  ch = 8'h43; // C
            PAT_BITS'(1):  ch = 8'h6F; // o
            PAT_BITS'(2):  ch = 8'h6E; // n
            PAT_BITS'(3):  ch = 8'h74; // t
            PAT_BITS'(4):  ch = 8'h65; // e
            PAT_BITS'(5):  ch = 8'h6E; // n
            PAT_BITS'(6):  ch = 8'h74; // t
            PAT_BITS'(7):  ch = 8'h2D; // -
            PAT_BITS'(8):  ch = 8'h54; // T
            PAT_BITS'(9):  ch = 8'h79; // y
            PAT_BITS'(10): ch = 8'h70; // p
            PAT_BITS'(11): ch = 8'h65; // e
            PAT_BITS'(12): ch = 8'h3A; // :
            PAT_BITS'(13): ch = 8'h20; // space
            default:       ch = 8'h43;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

[sv/http_content_type_extractor.sv]
// ----------------------------------------------------------------------------
// http_content_type_extractor: HTTP Content-Type value extractor
// Parses an Ethernet/IPv4/TCP frame byte by byte and emits the value that
// follows the first "Content-Type: " in the payload of a matching source.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (s_valid/s_ready) carries one frame byte per
//   transaction, with s_frame_last set on the final byte of the frame.
//   The result channel (m_valid/m_ready) carries at most one transaction per
//   input byte: a value byte, an end marker (carriage return reached) or a
//   void marker (frame or zero byte ended the value early; discard the bytes
//   already delivered for this frame).
//   Each byte is handled by the parse logic; its result is held in the
//   output register and appears in the cycle after acceptance.
//   One byte is taken per cycle while results are taken, through the single
//   output register: s_ready is high while that register is empty or is
//   being taken. When the receiver stalls, the result waits in the output
//   register and the input is held off until it is taken.
//   cfg_wr_en/cfg_wr_data write the source address (first wire byte in bits
//   31..24) in the cycle the enable is high. Reset (aresetn low, synchronous)
//   restores the address 127.0.0.1, empties the output register and returns
//   the parser to the start of a frame.
// ----------------------------------------------------------------------------
`default_nettype none

module http_content_type_extractor
    import hcte_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    // Input channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_frame_last,
    // Result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_value_byte,
    output logic             m_value_end,
    output logic             m_value_void
);

    localparam logic [POSITION_BITS-1:0] POS_MAX  = '1;
    localparam logic [POSITION_BITS-1:0] POS_LINK = POSITION_BITS'(LINK_HEADER_BYTES);
    localparam logic [POSITION_BITS-1:0] POS_ADDR_FIRST =
        POSITION_BITS'(LINK_HEADER_BYTES + 12);
    localparam logic [POSITION_BITS-1:0] POS_ADDR_LAST =
        POSITION_BITS'(LINK_HEADER_BYTES + 15);

    // State registers.
    logic [31:0]              source_address_reg;
    logic [POSITION_BITS-1:0] byte_position_reg, byte_position_next;
    logic [3:0]               ip_header_words_reg, ip_header_words_next;
    logic [3:0]               tcp_header_words_reg, tcp_header_words_next;
    logic                     address_equal_reg, address_equal_next;
    phase_t                   phase_reg, phase_next;
    logic [PAT_BITS-1:0]      pattern_progress_reg, pattern_progress_next;

    // Output register.
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_value_byte_reg, m_value_byte_next;
    logic       m_value_end_reg, m_value_end_next;
    logic       m_value_void_reg, m_value_void_next;

    logic                     s_accept;
    logic [POSITION_BITS-1:0] tcp_start;
    logic [POSITION_BITS-1:0] tcp_offset_pos;
    logic [POSITION_BITS-1:0] payload_start;
    logic [1:0]               addr_index;
    logic [7:0]               addr_want;
    logic [PAT_BITS-1:0]      pat_idx;

    // The input is taken whenever the output register is free this cycle.
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    // Header offsets derived from the stored length fields.
    assign tcp_start      = POS_LINK + POSITION_BITS'({ip_header_words_reg, 2'b00});
    assign tcp_offset_pos = tcp_start + POSITION_BITS'(12);
    assign payload_start  = tcp_start + POSITION_BITS'({tcp_header_words_reg, 2'b00});

    // Expected source address byte for the current header position.
    assign addr_index = byte_position_reg[1:0] - POS_ADDR_FIRST[1:0];
    always_comb begin
        case (addr_index)
            2'd0:    addr_want = source_address_reg[31:24];
            2'd1:    addr_want = source_address_reg[23:16];
            2'd2:    addr_want = source_address_reg[15:8];
            default: addr_want = source_address_reg[7:0];
        endcase
    end

    assign pat_idx = (pattern_progress_reg < PAT_BITS'(PAT_LEN)) ?
                     pattern_progress_reg : '0;

    // Per-byte parse step.
    always_comb begin
        byte_position_next    = byte_position_reg;
        ip_header_words_next  = ip_header_words_reg;
        tcp_header_words_next = tcp_header_words_reg;
        address_equal_next    = address_equal_reg;
        phase_next            = phase_reg;
        pattern_progress_next = pattern_progress_reg;
        m_valid_next          = m_valid_reg && !m_ready;
        m_value_byte_next     = m_value_byte_reg;
        m_value_end_next      = m_value_end_reg;
        m_value_void_next     = m_value_void_reg;

        if (s_accept) begin
            case (phase_reg)
                PH_HEADER: begin
                    if (byte_position_reg == POS_LINK) begin
                        ip_header_words_next = s_data_byte[3:0];
                    end
                    if (byte_position_reg >= POS_ADDR_FIRST &&
                        byte_position_reg <= POS_ADDR_LAST &&
                        s_data_byte != addr_want) begin
                        address_equal_next = 1'b0;
                    end
                    if (byte_position_reg > POS_LINK &&
                        byte_position_reg == tcp_offset_pos) begin
                        tcp_header_words_next = s_data_byte[7:4];
                    end
                    if (byte_position_reg > POS_LINK &&
                        byte_position_reg >= POS_ADDR_LAST &&
                        byte_position_reg >= tcp_offset_pos) begin
                        phase_next = address_equal_next ? PH_SEARCH : PH_DONE;
                    end
                end
                PH_SEARCH: begin
                    if (byte_position_reg >= payload_start) begin
                        if (s_data_byte == CHAR_NUL) begin
                            phase_next = PH_DONE;
                        end else if (s_data_byte == pattern_char(pat_idx)) begin
                            if (pat_idx == PAT_BITS'(PAT_LEN - 1)) begin
                                phase_next            = PH_VALUE;
                                pattern_progress_next = '0;
                            end else begin
                                pattern_progress_next = pat_idx + PAT_BITS'(1);
                            end
                        end else begin
                            pattern_progress_next = (s_data_byte == CHAR_C) ?
                                                    PAT_BITS'(1) : '0;
                        end
                    end
                end
                PH_VALUE: begin
                    m_valid_next      = 1'b1;
                    m_value_byte_next = 8'h00;
                    m_value_end_next  = 1'b0;
                    m_value_void_next = 1'b0;
                    if (s_data_byte == CHAR_CR) begin
                        m_value_end_next = 1'b1;
                        phase_next       = PH_DONE;
                    end else if (s_data_byte == CHAR_NUL || s_frame_last) begin
                        m_value_void_next = 1'b1;
                        phase_next        = PH_DONE;
                    end else begin
                        m_value_byte_next = s_data_byte;
                    end
                end
                default: begin
                end
            endcase

            // Frame end returns the parser to the start of a frame.
            if (s_frame_last) begin
                byte_position_next    = '0;
                ip_header_words_next  = '0;
                tcp_header_words_next = '0;
                address_equal_next    = 1'b1;
                phase_next            = PH_HEADER;
                pattern_progress_next = '0;
            end else if (byte_position_reg != POS_MAX) begin
                byte_position_next = byte_position_reg + POSITION_BITS'(1);
            end
        end
    end

    // Control and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_address_reg   <= SOURCE_ADDRESS_RESET;
            byte_position_reg    <= '0;
            ip_header_words_reg  <= '0;
            tcp_header_words_reg <= '0;
            address_equal_reg    <= 1'b1;
            phase_reg            <= PH_HEADER;
            pattern_progress_reg <= '0;
            m_valid_reg          <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                source_address_reg <= cfg_wr_data;
            end
            byte_position_reg    <= byte_position_next;
            ip_header_words_reg  <= ip_header_words_next;
            tcp_header_words_reg <= tcp_header_words_next;
            address_equal_reg    <= address_equal_next;
            phase_reg            <= phase_next;
            pattern_progress_reg <= pattern_progress_next;
            m_valid_reg          <= m_valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge aclk) begin
        m_value_byte_reg <= m_value_byte_next;
        m_value_end_reg  <= m_value_end_next;
        m_value_void_reg <= m_value_void_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_value_byte = m_value_byte_reg;
    assign m_value_end  = m_value_end_reg;
    assign m_value_void = m_value_void_reg;

`ifndef SYNTHESIS
    // A result never marks both the end and the void case.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_value_end_reg && m_value_void_reg))
        else $error("result marks both end and void");

    // Marker results carry a zero byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_value_end_reg || m_value_void_reg)) |->
        (m_value_byte_reg == 8'h00))
        else $error("marker result carries a non-zero byte");

    // Only a byte taken inside the value produces a result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && phase_reg != PH_VALUE) |=> !m_valid_reg)
        else $error("result produced outside the value phase");

    // The final byte of a frame restarts the parser.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_frame_last) |=>
        (phase_reg == PH_HEADER && byte_position_reg == '0 && address_equal_reg))
        else $error("parser not restarted after frame end");

    // The search progress stays inside the pattern.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pattern_progress_reg < PAT_BITS'(PAT_LEN))
        else $error("pattern progress out of range");
`endif

endmodule

`default_nettype wire

[test/http_content_type_extractor_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_content_type_extractor_tb: self-checking bench for the extractor
// Builds Ethernet/IPv4/TCP frames with and without a Content-Type header and
// streams them byte by byte, with random gaps on the input side and random
// stalls on the result side. A behavioural model of the parser predicts every
// result transaction, and the monitor compares each one field by field. The
// source address register is changed between frames, between phases of the
// run.
// ----------------------------------------------------------------------------

module http_content_type_extractor_tb;
    import hcte_pkg::*;

    // Watchdog limit in cycles without any accepted transaction.
    localparam int STUCK_LIMIT = 2000;
    // Printed mismatch lines are capped so that a broken block cannot flood the log.
    localparam int MAX_REPORTS = 100;
    localparam int POS_MAX     = (1 << POSITION_BITS) - 1;
    localparam logic [8*PAT_LEN-1:0] CT_TEXT = "Content-Type: ";

    // Shapes of generated frames.
    typedef enum int {
        FK_VALUE_CR,    // value closed by a carriage return
        FK_VALUE_LAST,  // frame ends inside the value
        FK_VALUE_ZERO,  // zero byte inside the value
        FK_SEARCH_ZERO, // zero byte before the header
        FK_NO_PATTERN,  // payload without the header
        FK_CUT_SHORT,   // well-formed frame truncated at a random byte
        FK_NOISE        // random bytes only
    } frame_kind_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_item_t;

    typedef struct packed {
        logic [7:0] vbyte;
        logic       vend;
        logic       vvoid;
    } ctype_result_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = 32'h0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_frame_last = 1'b0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [7:0]  m_value_byte;
    logic        m_value_end;
    logic        m_value_void;

    http_content_type_extractor i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_frame_last (s_frame_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value_byte (m_value_byte),
        .m_value_end  (m_value_end),
        .m_value_void (m_value_void)
    );

    // Clock, 12 ns period.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    frame_item_t   frame_bytes[$];   // bytes waiting to be sent
    logic [7:0]    frame_buf[$];     // frame under construction
    ctype_result_t ctype_results[$]; // predicted result transactions
    frame_item_t   next_item;
    ctype_result_t want;

    int   errors       = 0;
    int   n_results    = 0;
    int   stuck_cycles = 0;
    int   send_gap     = 0;
    int   stall_left   = 0;
    bit   quiet        = 1'b0;
    logic s_taken      = 1'b0;

    // Model state of the parser.
    logic [31:0] src_addr = SOURCE_ADDRESS_RESET;
    int          at_pos   = 0;
    logic [3:0]  ihl_words  = 4'h0;
    logic [3:0]  doff_words = 4'h0;
    bit          src_match  = 1'b1;
    phase_t      phase_now  = PH_HEADER;
    int          pat_hits   = 0;

    // Character k of the header name being searched for.
    function automatic logic [7:0] ct_char(input int k);
        return CT_TEXT[8*(PAT_LEN-1-k) +: 8];
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] value_char();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255)); while (b == CHAR_CR);
        return b;
    endfunction

    task automatic report_mismatch(input string msg);
        if (errors < MAX_REPORTS)
            $display("mismatch at result %0d: %s", n_results, msg);
        errors++;
    endtask

    task automatic restart_frame();
        at_pos     = 0;
        ihl_words  = 4'h0;
        doff_words = 4'h0;
        src_match  = 1'b1;
        phase_now  = PH_HEADER;
        pat_hits   = 0;
    endtask

    // Advances the parser model by one byte and queues any result it gives.
    task automatic parse_frame_byte(input logic [7:0] c, input logic last);
        int            tcp_start;
        int            k;
        int            idx;
        ctype_result_t r;
        tcp_start = LINK_HEADER_BYTES + 4 * int'(ihl_words);
        r = '0;
        case (phase_now)
            PH_HEADER: begin
                if (at_pos == LINK_HEADER_BYTES) begin
                    ihl_words = c[3:0];
                    tcp_start = LINK_HEADER_BYTES + 4 * int'(ihl_words);
                end
                if (at_pos >= LINK_HEADER_BYTES + 12 && at_pos <= LINK_HEADER_BYTES + 15) begin
                    k = at_pos - (LINK_HEADER_BYTES + 12);
                    if (c != 8'(src_addr >> (24 - 8 * k)))
                        src_match = 1'b0;
                end
                if (at_pos > LINK_HEADER_BYTES && at_pos == tcp_start + 12)
                    doff_words = c[7:4];
                if (at_pos > LINK_HEADER_BYTES && at_pos >= LINK_HEADER_BYTES + 15
                        && at_pos >= tcp_start + 12) begin
                    if (src_match)
                        phase_now = PH_SEARCH;
                    else
                        phase_now = PH_DONE;
                end
            end
            PH_SEARCH: begin
                if (at_pos >= tcp_start + 4 * int'(doff_words)) begin
                    idx = (pat_hits < PAT_LEN) ? pat_hits : 0;
                    if (c == CHAR_NUL) begin
                        phase_now = PH_DONE;
                    end else if (c == ct_char(idx)) begin
                        idx++;
                        if (idx == PAT_LEN) begin
                            phase_now = PH_VALUE;
                            idx = 0;
                        end
                        pat_hits = idx;
                    end else begin
                        pat_hits = (c == CHAR_C) ? 1 : 0;
                    end
                end
            end
            PH_VALUE: begin
                if (c == CHAR_CR) begin
                    r.vend = 1'b1;
                    phase_now = PH_DONE;
                end else if (c == CHAR_NUL || last) begin
                    r.vvoid = 1'b1;
                    phase_now = PH_DONE;
                end else begin
                    r.vbyte = c;
                end
                ctype_results.push_back(r);
            end
            default: ;
        endcase
        if (last)
            restart_frame();
        else if (at_pos < POS_MAX)
            at_pos++;
    endtask

    // Builds one frame into frame_buf. For noise frames vlen is the length.
    task automatic make_frame(input frame_kind_t kind, input bit match, input int ihl,
                              input int doff, input int vlen, input int fill,
                              input int cut, input bit second);
        logic [7:0]  hdr [0:159];
        logic [31:0] addr;
        int          tcp_start;
        int          start;
        int          k;
        frame_buf.delete();
        if (kind == FK_NOISE) begin
            repeat (vlen) frame_buf.push_back(8'($urandom_range(0, 255)));
            return;
        end
        // Header: random bytes with the length fields and source address set.
        for (k = 0; k < 160; k++)
            hdr[k] = 8'($urandom_range(0, 255));
        tcp_start = LINK_HEADER_BYTES + 4 * ihl;
        hdr[LINK_HEADER_BYTES] = {4'h4, 4'(ihl)};
        hdr[tcp_start + 12][7:4] = 4'(doff);
        addr = src_addr;
        if (!match)
            addr ^= 32'h1 << $urandom_range(0, 31);
        for (k = 0; k < 4; k++)
            hdr[LINK_HEADER_BYTES + 12 + k] = 8'(addr >> (24 - 8 * k));
        // With very short headers the offset byte may overlap the address.
        start = LINK_HEADER_BYTES + 16;
        if (tcp_start + 13 > start)
            start = tcp_start + 13;
        if (tcp_start + 4 * int'(hdr[tcp_start + 12][7:4]) > start)
            start = tcp_start + 4 * int'(hdr[tcp_start + 12][7:4]);
        for (k = 0; k < start; k++)
            frame_buf.push_back(hdr[k]);
        // Payload.
        repeat (fill) frame_buf.push_back(8'($urandom_range(1, 255)));
        if (kind == FK_SEARCH_ZERO)
            frame_buf.push_back(CHAR_NUL);
        if (kind != FK_NO_PATTERN) begin
            for (k = 0; k < cut; k++)
                frame_buf.push_back(ct_char(k));
            for (k = 0; k < PAT_LEN; k++)
                frame_buf.push_back(ct_char(k));
            repeat (vlen) frame_buf.push_back(value_char());
            if (kind == FK_VALUE_LAST)
                return;
            if (kind == FK_VALUE_ZERO)
                frame_buf.push_back(CHAR_NUL);
            else
                frame_buf.push_back(CHAR_CR);
        end
        if (second) begin
            for (k = 0; k < PAT_LEN; k++)
                frame_buf.push_back(ct_char(k));
            frame_buf.push_back(value_char());
            frame_buf.push_back(CHAR_CR);
        end
        repeat ($urandom_range(0, 4)) frame_buf.push_back(8'($urandom_range(0, 255)));
        if (kind == FK_CUT_SHORT) begin
            k = $urandom_range(1, frame_buf.size());
            while (frame_buf.size() > k)
                void'(frame_buf.pop_back());
        end
    endtask

    // Waits until every byte is accepted and every predicted result has come.
    task automatic wait_drained();
        do @(posedge aclk); while (frame_bytes.size() != 0 || s_valid);
        do @(negedge aclk); while (ctype_results.size() != 0);
    endtask

    // Hands frame_buf to the driver; a non-zero split pauses the sender there
    // until the block has delivered everything owed so far.
    task automatic queue_frame(input int split);
        frame_item_t it;
        int          i;
        for (i = 0; i < frame_buf.size(); i++) begin
            if (split > 0 && i == split)
                wait_drained();
            it.data = frame_buf[i];
            it.last = (i == frame_buf.size() - 1);
            frame_bytes.push_back(it);
        end
    endtask

    task automatic write_source(input logic [31:0] v);
        wait_drained();
        repeat (4) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        src_addr = v;
    endtask

    function automatic int header_words();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 5;
        else if (r < 75)
            return $urandom_range(0, 4);
        else
            return $urandom_range(6, 15);
    endfunction

    // Random frames, mostly well formed, until the byte budget is used.
    task automatic random_phase(input int budget);
        frame_kind_t kind;
        int          sent;
        int          r;
        int          vlen;
        int          split;
        sent = 0;
        while (sent < budget) begin
            r = $urandom_range(0, 99);
            if (r < 55)
                kind = FK_VALUE_CR;
            else if (r < 67)
                kind = FK_VALUE_LAST;
            else if (r < 75)
                kind = FK_VALUE_ZERO;
            else if (r < 80)
                kind = FK_SEARCH_ZERO;
            else if (r < 85)
                kind = FK_NO_PATTERN;
            else if (r < 92)
                kind = FK_CUT_SHORT;
            else
                kind = FK_NOISE;
            vlen = (kind == FK_NOISE) ? $urandom_range(1, 40) : $urandom_range(0, 10);
            quiet = ($urandom_range(0, 4) == 0);
            make_frame(kind, $urandom_range(0, 99) < 85, header_words(), header_words(),
                       vlen, $urandom_range(0, 6),
                       ($urandom_range(0, 9) < 3) ? $urandom_range(1, PAT_LEN - 1) : 0,
                       $urandom_range(0, 99) < 15);
            split = ($urandom_range(0, 19) == 0) ? $urandom_range(1, frame_buf.size()) : 0;
            sent += frame_buf.size();
            queue_frame(split);
        end
        quiet = 1'b0;
    endtask

    // Input driver: payload changes on the falling edge.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else if (!s_valid || s_taken) begin
            if (send_gap > 0) begin
                s_valid  <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (frame_bytes.size() != 0) begin
                next_item    = frame_bytes.pop_front();
                s_valid      <= 1'b1;
                s_data_byte  <= next_item.data;
                s_frame_last <= next_item.last;
                send_gap     <= idle_length();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side back-pressure.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready    <= 1'b1;
            stall_left <= idle_length();
        end
    end

    // Monitor: checks result transactions, predicts from accepted input
    // transactions, and watches for a hang.
    always @(posedge aclk) begin
        if (!aresetn) begin
            restart_frame();
            src_addr = SOURCE_ADDRESS_RESET;
            s_taken      <= 1'b0;
            stuck_cycles <= 0;
        end else begin
            s_taken <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                if (ctype_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result byte %02h end %0b void %0b",
                                              m_value_byte, m_value_end, m_value_void));
                end else begin
                    want = ctype_results.pop_front();
                    if (m_value_byte !== want.vbyte)
                        report_mismatch($sformatf("value byte %02h, expected %02h",
                                                  m_value_byte, want.vbyte));
                    if (m_value_end !== want.vend)
                        report_mismatch($sformatf("end flag %0b, expected %0b",
                                                  m_value_end, want.vend));
                    if (m_value_void !== want.vvoid)
                        report_mismatch($sformatf("void flag %0b, expected %0b",
                                                  m_value_void, want.vvoid));
                end
                n_results++;
            end
            if (s_valid && s_ready)
                parse_frame_byte(s_data_byte, s_frame_last);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stuck_cycles <= 0;
            end else if (stuck_cycles + 1 >= STUCK_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end else begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

    // Stimulus sequence.
    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed frames under the reset address. The first one pauses the
        // sender halfway until every result owed so far has come.
        make_frame(FK_VALUE_CR, 1, 5, 5, 9, 4, 0, 0);
        queue_frame(frame_buf.size() / 2);
        make_frame(FK_VALUE_LAST, 1, 0, 0, 5, 0, 0, 0);
        queue_frame(0);
        make_frame(FK_VALUE_ZERO, 1, 0, 0, 3, 0, 0, 0);
        queue_frame(0);
        make_frame(FK_SEARCH_ZERO, 1, 0, 0, 4, 3, 0, 0);
        queue_frame(0);
        make_frame(FK_VALUE_CR, 0, 0, 0, 4, 1, 0, 0);
        queue_frame(0);

        write_source(32'h0000_0000);
        random_phase(30);
        write_source(32'hFFFF_FFFF);
        random_phase(30);
        write_source($urandom());
        random_phase(30);
        write_source(SOURCE_ADDRESS_RESET);
        random_phase(30);

        wait_drained();
        repeat (8) @(negedge aclk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
